[rtl/tsrt_pkg.sv]
// Shared types and constants for the triggered shift register tap.
// Used by tsrt_stage_calc and triggered_shift_register_tap; depends on nothing.
`timescale 1ns / 1ps

package tsrt_pkg;

    // Width of the configuration register index and write data.
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;

    // Signed width used while the stage is worked out, before clamping.
    localparam int STAGE_CALC_W = 13;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PRE_DELAY      = 4'd0,
        CFG_STAGE_KNOB     = 4'd1,
        CFG_ATTENUVERTER   = 4'd2,
        CFG_TRIG_THRESHOLD = 4'd3
    } cfg_index_t;

    // Reset values of the configuration registers.
    localparam logic [2:0]         PRE_DELAY_RST      = 3'd1;
    localparam logic [6:0]         STAGE_KNOB_RST     = 7'd1;
    localparam logic signed [9:0]  ATTENUVERTER_RST   = 10'sd0;
    localparam logic signed [15:0] TRIG_THRESHOLD_RST = 16'sd1638;

    // Configuration that sets the selected stage.
    typedef struct packed {
        logic [6:0]        stage_knob;
        logic signed [9:0] attenuverter;
    } stage_cfg_t;

endpackage

[rtl/tsrt_stage_calc.sv]
// Stage selection for the triggered shift register tap: knob, CV and gain
// combined and clamped to 1..RING_DEPTH. Depends on tsrt_pkg.
`timescale 1ns / 1ps

module tsrt_stage_calc #(
    parameter int RING_DEPTH = 64,
    parameter int STAGE_W    = 7
) (
    input  tsrt_pkg::stage_cfg_t cfg,
    input  logic signed [15:0]   stage_cv,
    input  logic                 stage_cv_present,
    output logic [STAGE_W-1:0]   stage
);

    localparam int CW = tsrt_pkg::STAGE_CALC_W;
    localparam logic signed [CW-1:0] DEPTH_S = CW'(RING_DEPTH);

    logic signed [25:0]   cv_prod;
    logic signed [25:0]   cv_adj;
    logic signed [9:0]    cv_q;
    logic signed [10:0]   gain;
    logic signed [18:0]   knob_prod;
    logic signed [18:0]   knob_adj;
    logic signed [10:0]   knob_q;
    logic signed [CW-1:0] st_sum;

    // CV path: knob plus CV times gain over 65536, truncated toward zero.
    assign cv_prod = stage_cv * cfg.attenuverter;
    assign cv_adj  = cv_prod + (cv_prod[25] ? 26'sd65535 : 26'sd0);
    assign cv_q    = cv_adj[25:16];

    // Knob path: knob times (256 - gain) over 256, truncated toward zero.
    assign gain      = 11'sd256 - 11'(cfg.attenuverter);
    assign knob_prod = $signed({12'd0, cfg.stage_knob}) * 19'(gain);
    assign knob_adj  = knob_prod + (knob_prod[18] ? 19'sd255 : 19'sd0);
    assign knob_q    = knob_adj[18:8];

    assign st_sum = stage_cv_present ? ($signed({6'd0, cfg.stage_knob}) + CW'(cv_q))
                                     : CW'(knob_q);

    // Clamp into the ring.
    always_comb
    begin
        if (st_sum < CW'(1))
            stage = STAGE_W'(1);
        else if (st_sum > DEPTH_S)
            stage = STAGE_W'(RING_DEPTH);
        else
            stage = STAGE_W'(st_sum);
    end

endmodule

[rtl/triggered_shift_register_tap.sv]
// Triggered shift register with a movable tap: one transaction in, one out,
// one transaction per clock cycle sustained unless m_axis_tready holds the
// pipeline, passing through stage calculation, ring read and output register.
// The ring memory takes one write and one read per cycle; a read that
// hits the entry written in the same cycle is forwarded. The ring needs no
// clearing pass after reset: a wrap flag and the write pointer make
// never-written entries read as zero, so items are accepted from the
// first cycle after reset. Depends on tsrt_pkg and tsrt_stage_calc.
`timescale 1ns / 1ps

module triggered_shift_register_tap #(
    parameter int RING_DEPTH  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,

    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: trig_level [15:0], sample_in [31:16], stage_cv [47:32]
    input  logic [47:0] s_axis_tdata,
    // tuser: trig_present [0], stage_cv_present [1]
    input  logic [1:0]  s_axis_tuser,

    // Output stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: sample_out [SAMPLE_BITS-1:0], stage_now [SAMPLE_BITS+6:SAMPLE_BITS], zero fill
    output logic [((SAMPLE_BITS+14)/8)*8-1:0] m_axis_tdata,

    // Configuration write channel.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tsrt_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [tsrt_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int SW = $clog2(RING_DEPTH + 1);
    localparam int IW = $clog2(2 * RING_DEPTH);

    // Configuration registers.
    logic [2:0]         pre_delay_reg;
    logic [6:0]         stage_knob_reg;
    logic signed [9:0]  attenuverter_reg;
    logic signed [15:0] trig_threshold_reg;

    // Tap state.
    logic [AW-1:0] wp_reg;
    logic          wrapped_reg;
    logic [2:0]    delay_count_reg;
    logic          armed_reg;
    logic          was_high_reg;
    logic [SW-1:0] last_stage_reg;
    logic [SAMPLE_BITS-1:0] held_reg;

    // Pipeline registers.
    logic                   p1_valid_reg;
    logic [SW-1:0]          p1_stage_reg;
    logic signed [15:0]     p1_level_reg;
    logic                   p1_present_reg;
    logic [SAMPLE_BITS-1:0] p1_sample_reg;

    logic                   p2_valid_reg;
    logic                   p2_rd_reg;
    logic                   p2_fwd_reg;
    logic                   p2_entry_ok_reg;
    logic [SW-1:0]          p2_stage_reg;
    logic [SAMPLE_BITS-1:0] p2_sample_reg;
    logic [SAMPLE_BITS-1:0] rdata_reg;

    logic                   m_valid_reg;
    logic [SAMPLE_BITS-1:0] out_sample_reg;
    logic [6:0]             out_stage_reg;

    logic [SAMPLE_BITS-1:0] ring [RING_DEPTH];

    tsrt_pkg::stage_cfg_t stage_cfg;
    logic [SW-1:0]        stage_calc;
    logic                 adv;
    logic                 p1_go;
    logic                 changed;
    logic                 high;
    logic                 armed_eff;
    logic                 do_write;
    logic [AW-1:0]        wp_inc;
    logic [AW-1:0]        wp_next;
    logic                 wrapped_next;
    logic [IW-1:0]        idx_sum;
    logic [AW-1:0]        rd_addr;
    logic                 entry_ok;
    logic                 rd_en;
    logic                 fwd;
    logic [SAMPLE_BITS-1:0] held_next;

    // The whole pipeline moves when the output register can take an item.
    assign adv           = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign cfg_ready     = 1'b1;
    assign p1_go         = adv && p1_valid_reg;

    // Stage selection, registered into the first pipeline stage.
    assign stage_cfg.stage_knob   = stage_knob_reg;
    assign stage_cfg.attenuverter = attenuverter_reg;

    tsrt_stage_calc #(
        .RING_DEPTH(RING_DEPTH),
        .STAGE_W   (SW)
    ) u_stage_calc (
        .cfg             (stage_cfg),
        .stage_cv        ($signed(s_axis_tdata[47:32])),
        .stage_cv_present(s_axis_tuser[1]),
        .stage           (stage_calc)
    );

    // Trigger edge detection and write decision.
    always_comb
    begin
        changed   = p1_stage_reg != last_stage_reg;
        high      = p1_level_reg >= trig_threshold_reg;
        armed_eff = armed_reg || (p1_present_reg && high && !was_high_reg);
        do_write  = p1_present_reg && armed_eff && (delay_count_reg >= pre_delay_reg);
        wp_inc    = (wp_reg == AW'(RING_DEPTH - 1)) ? '0 : wp_reg + AW'(1);
        wp_next   = do_write ? wp_inc : wp_reg;
        wrapped_next = wrapped_reg || (do_write && (wp_reg == AW'(RING_DEPTH - 1)));
    end

    // Tap address after this item's write, wrapped into the ring.
    always_comb
    begin
        idx_sum  = IW'(wp_next) + IW'(RING_DEPTH) - IW'(p1_stage_reg);
        rd_addr  = (idx_sum >= IW'(RING_DEPTH)) ? AW'(idx_sum - IW'(RING_DEPTH))
                                                 : AW'(idx_sum);
        entry_ok = wrapped_next || (rd_addr < wp_next);
        rd_en    = changed || do_write;
        fwd      = do_write && (p1_stage_reg == SW'(1));
    end

    // Ring memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (p1_go && do_write)
            ring[wp_reg] <= p1_sample_reg;
        if (p1_go && rd_en)
            rdata_reg <= ring[rd_addr];
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_delay_reg      <= tsrt_pkg::PRE_DELAY_RST;
            stage_knob_reg     <= tsrt_pkg::STAGE_KNOB_RST;
            attenuverter_reg   <= tsrt_pkg::ATTENUVERTER_RST;
            trig_threshold_reg <= tsrt_pkg::TRIG_THRESHOLD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                tsrt_pkg::CFG_PRE_DELAY:      pre_delay_reg      <= cfg_data[2:0];
                tsrt_pkg::CFG_STAGE_KNOB:     stage_knob_reg     <= cfg_data[6:0];
                tsrt_pkg::CFG_ATTENUVERTER:   attenuverter_reg   <= $signed(cfg_data[9:0]);
                tsrt_pkg::CFG_TRIG_THRESHOLD: trig_threshold_reg <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    // Tap state update, one item per cycle while the pipeline advances.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg          <= '0;
            wrapped_reg     <= 1'b0;
            delay_count_reg <= '0;
            armed_reg       <= 1'b0;
            was_high_reg    <= 1'b0;
            last_stage_reg  <= SW'(1);
        end
        else if (p1_go)
        begin
            last_stage_reg <= p1_stage_reg;
            wp_reg         <= wp_next;
            wrapped_reg    <= wrapped_next;
            if (p1_present_reg)
            begin
                was_high_reg <= high;
                if (armed_eff)
                begin
                    if (do_write)
                    begin
                        delay_count_reg <= '0;
                        armed_reg       <= 1'b0;
                    end
                    else
                    begin
                        delay_count_reg <= delay_count_reg + 3'd1;
                        armed_reg       <= 1'b1;
                    end
                end
            end
        end
    end

    // Pipeline valid bits and the held output.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            held_reg     <= '0;
        end
        else if (adv)
        begin
            p1_valid_reg <= s_axis_tvalid;
            p2_valid_reg <= p1_valid_reg;
            m_valid_reg  <= p2_valid_reg;
            if (p2_valid_reg)
                held_reg <= held_next;
        end
    end

    // Pipeline payload.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_stage_reg    <= stage_calc;
            p1_level_reg    <= $signed(s_axis_tdata[15:0]);
            p1_present_reg  <= s_axis_tuser[0];
            p1_sample_reg   <= SAMPLE_BITS'(s_axis_tdata[31:16]);
            p2_rd_reg       <= rd_en;
            p2_fwd_reg      <= fwd;
            p2_entry_ok_reg <= entry_ok;
            p2_stage_reg    <= p1_stage_reg;
            p2_sample_reg   <= p1_sample_reg;
            out_sample_reg  <= held_next;
            out_stage_reg   <= 7'(p2_stage_reg);
        end
    end

    // New held value: the tap read, the forwarded sample, zero for a never-written entry, or the old value.
    always_comb
    begin
        if (!p2_rd_reg)
            held_next = held_reg;
        else if (p2_fwd_reg)
            held_next = p2_sample_reg;
        else if (p2_entry_ok_reg)
            held_next = rdata_reg;
        else
            held_next = '0;
    end

    // Output packing.
    assign m_axis_tvalid = m_valid_reg;
    always_comb
    begin
        m_axis_tdata = '0;
        m_axis_tdata[SAMPLE_BITS-1:0]  = out_sample_reg;
        m_axis_tdata[SAMPLE_BITS +: 7] = out_stage_reg;
    end

    // A pending delay count exists only while a write is armed.
    a_count_needs_arm: assert property (@(posedge clk) disable iff (!rst_n)
        !armed_reg |-> delay_count_reg == 3'd0)
        else $error("delay count nonzero while disarmed");

    // The write pointer stays inside the ring.
    a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wp_reg <= AW'(RING_DEPTH - 1))
        else $error("write pointer outside ring");

    // The remembered stage is always a clamped stage.
    a_last_stage_bound: assert property (@(posedge clk) disable iff (!rst_n)
        last_stage_reg >= SW'(1) && last_stage_reg <= SW'(RING_DEPTH))
        else $error("last stage out of range");

    // Every committed write advances the pointer.
    a_write_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (p1_go && do_write) |=> wp_reg != $past(wp_reg))
        else $error("write did not advance pointer");

endmodule
